// ===== rtl/bdts_pkg.sv =====
// shared types and constants for the byte translate/delete/squeeze filter
`default_nettype none
package bdts_pkg;

   localparam int MAX_SET_DEF = 16;
   localparam int CSR_W       = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int LEN_W       = 5;

   localparam logic [1:0] MODE_TRANSLATE = 2'd0;
   localparam logic [1:0] MODE_DELETE    = 2'd1;
   localparam logic [1:0] MODE_SQUEEZE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FROM_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FROM_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TO_LOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TO_HIGH   = 3'd5;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       member;
   } item_type;

endpackage
`default_nettype wire

// ===== rtl/byte_translate_delete_squeeze.sv =====
// top level: tr-style byte filter built as a chain of compare/replace cells
// a beat accepted passes through every cell register and then the output register before it shows on rsp
// throughput: one beat per cycle while rsp_stall does not hold the chain; each cell stage holds one beat in flight
// the whole chain holds while a result waits and rsp_stall is high
// reset clears the CSRs, cell stages, valid bits and the last emitted byte, but not the output byte register
// results come out in input order, zero or one per beat
`default_nettype none
module byte_translate_delete_squeeze #(
   parameter int MAX_SET = bdts_pkg::MAX_SET_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_in_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [7:0]                          rsp_out_byte,
   input  wire logic                           csr_we,
   input  wire logic [bdts_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bdts_pkg::CSR_W-1:0]     csr_wdata
);
   import bdts_pkg::*;

   logic [1:0]       mode_ff;
   logic [LEN_W-1:0] set_len_ff;
   logic [CSR_W-1:0] from_low_ff, from_high_ff, to_low_ff, to_high_ff;
   logic [LEN_W-1:0] active_len;
   logic             advance;
   logic             translate;
   item_type         chain [MAX_SET+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TRANSLATE;
         set_len_ff   <= '0;
         from_low_ff  <= '0;
         from_high_ff <= '0;
         to_low_ff    <= '0;
         to_high_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:      mode_ff      <= csr_wdata[1:0];
            CSR_SET_LEN:   set_len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_FROM_LOW:  from_low_ff  <= csr_wdata;
            CSR_FROM_HIGH: from_high_ff <= csr_wdata;
            CSR_TO_LOW:    to_low_ff    <= csr_wdata;
            CSR_TO_HIGH:   to_high_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign active_len = (set_len_ff > LEN_W'(MAX_SET)) ? LEN_W'(MAX_SET) : set_len_ff;
   assign translate  = (mode_ff == MODE_TRANSLATE);
   assign req_stall  = !advance;

   always_comb begin
      chain[0].valid  = req_valid;
      chain[0].data   = req_in_byte;
      chain[0].member = (req_in_byte == 8'd0);
   end

   for (genvar i = 0; i < MAX_SET; i++) begin : g_cell
      logic [7:0] from_char, to_char;
      if (i < 8) begin : g_low
         assign from_char = from_low_ff[8*i +: 8];
         assign to_char   = to_low_ff[8*i +: 8];
      end else begin : g_high
         assign from_char = from_high_ff[8*(i-8) +: 8];
         assign to_char   = to_high_ff[8*(i-8) +: 8];
      end

      bdts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .enable    (LEN_W'(i) < active_len),
         .translate (translate),
         .from_char (from_char),
         .to_char   (to_char),
         .item_in   (chain[i]),
         .item_out  (chain[i+1])
      );
   end

   bdts_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .mode         (mode_ff),
      .item_in      (chain[MAX_SET]),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule
`default_nettype wire

// ===== rtl/bdts_cell.sv =====
// one compare/replace cell of the filter chain, holding one in-flight beat
`default_nettype none
module bdts_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              enable,
   input  wire logic              translate,
   input  wire logic [7:0]        from_char,
   input  wire logic [7:0]        to_char,
   input  wire bdts_pkg::item_type item_in,
   output bdts_pkg::item_type      item_out
);
   import bdts_pkg::*;

   item_type stage_ff, stage_in;
   logic     hit;

   always_comb begin
      hit      = enable && (item_in.data == from_char);
      stage_in = item_in;
      if (hit && translate) begin
         stage_in.data = to_char;
      end
      stage_in.member = item_in.member | hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign item_out = stage_ff;

endmodule
`default_nettype wire

// ===== rtl/bdts_emit.sv =====
// end of chain: delete/squeeze decision, last emitted byte and output register
`default_nettype none
module bdts_emit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [1:0]         mode,
   input  wire bdts_pkg::item_type item_in,
   output logic                    advance,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte
);
   import bdts_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [7:0] last_ff, last_in;
   logic       last_valid_ff, last_valid_in;
   logic       drop;

   assign advance = !out_valid_ff || !rsp_stall;

   always_comb begin
      case (mode)
         MODE_TRANSLATE: drop = 1'b0;
         MODE_DELETE:    drop = item_in.member;
         MODE_SQUEEZE:   drop = item_in.member && last_valid_ff && (last_ff == item_in.data);
         default:        drop = 1'b0;
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      last_in       = last_ff;
      last_valid_in = last_valid_ff;
      if (advance) begin
         out_valid_in = item_in.valid && !drop;
         if (item_in.valid && !drop) begin
            out_byte_in   = item_in.data;
            last_in       = item_in.data;
            last_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         last_valid_ff <= 1'b0;
         last_ff       <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         last_valid_ff <= last_valid_in;
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;

   // a translate beat leaving the chain always yields a result
   a_translate_emits: assert property (@(posedge clock) disable iff (reset)
      (advance && item_in.valid && mode == MODE_TRANSLATE) |=> rsp_valid)
      else $error("translate beat produced no result");

   // a set member in delete mode never reaches the output
   a_delete_drops: assert property (@(posedge clock) disable iff (reset)
      (advance && item_in.valid && item_in.member && mode == MODE_DELETE) |=> !rsp_valid)
      else $error("deleted beat was emitted");

   // the held result is always the last emitted byte
   a_last_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_valid_ff && last_ff == rsp_out_byte))
      else $error("last emitted byte out of step with output");

endmodule
`default_nettype wire
